// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file sldf_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/sldf_pkg.sv =====
`default_nettype none

package sldf_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int EVENT_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'hAA;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 16'd256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'd1;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_DATA     = 3'd1,
        EV_GOOD     = 3'd2,
        EV_BAD      = 3'd3,
        EV_OVERSIZE = 3'd4
    } t_event;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [LEN_W-1:0]  max_payload_len;
    } t_cfg;

    typedef struct packed {
        t_event            ev_code;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  payload_offset;
        logic [BYTE_W-1:0] frame_cmd;
        logic [LEN_W-1:0]  frame_len;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/sldf_in_if.sv =====
`default_nettype none

interface sldf_in_if;
    import sldf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/sldf_out_if.sv =====
`default_nettype none

interface sldf_out_if;
    import sldf_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  data_byte;
    logic [LEN_W-1:0]   payload_offset;
    logic [BYTE_W-1:0]  frame_cmd;
    logic [LEN_W-1:0]   frame_len;

    modport source (output valid, output event_res, output data_byte,
                    output payload_offset, output frame_cmd, output frame_len,
                    input ready);
    modport sink   (input valid, input event_res, input data_byte,
                    input payload_offset, input frame_cmd, input frame_len,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/sldf_fsm.sv =====
`default_nettype none

// Frame parser: holds frame state, computes the result of the current byte.
module sldf_fsm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [sldf_pkg::BYTE_W-1:0]   i_rx_byte,
    input  sldf_pkg::t_cfg                i_cfg,
    output sldf_pkg::t_result             o_res
);
    import sldf_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic [BYTE_W-1:0] r_xacc, n_xacc;

    logic [LEN_W:0]    off_inc;
    logic [LEN_W-1:0]  len_full;

    assign off_inc  = {1'b0, r_idx} + {{LEN_W{1'b0}}, 1'b1};
    // low length byte joins the high byte kept from the previous step
    assign len_full = {r_len[LEN_W-1:BYTE_W], i_rx_byte};

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_idx   = r_idx;
        n_xacc  = r_xacc;
        o_res.ev_code        = EV_NONE;
        o_res.data_byte      = '0;
        o_res.payload_offset = '0;
        case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == i_cfg.sync_value) begin
                    n_phase = PH_CMD;
                    n_xacc  = '0;
                end
            end
            PH_CMD: begin
                n_cmd   = i_rx_byte;
                n_xacc  = r_xacc ^ i_rx_byte;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {i_rx_byte, {BYTE_W{1'b0}}};
                n_xacc  = r_xacc ^ i_rx_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len  = len_full;
                n_xacc = r_xacc ^ i_rx_byte;
                n_idx  = '0;
                if (len_full > i_cfg.max_payload_len) begin
                    o_res.ev_code = EV_OVERSIZE;
                    n_phase       = PH_HUNT;
                end else if (len_full == '0) begin
                    n_phase = PH_CHECK;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_res.ev_code        = EV_DATA;
                o_res.data_byte      = i_rx_byte;
                o_res.payload_offset = r_idx;
                n_xacc = r_xacc ^ i_rx_byte;
                n_idx  = off_inc[LEN_W-1:0];
                if (off_inc >= {1'b0, r_len}) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_res.ev_code = (i_rx_byte == r_xacc) ? EV_GOOD : EV_BAD;
                n_phase       = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
        o_res.frame_cmd = n_cmd;
        o_res.frame_len = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_idx   <= '0;
            r_xacc  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_xacc  <= n_xacc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sync_length_xor_deframer_core.sv =====
`default_nettype none

// Channel   Dir  Payload                                             Width
// i_in_ch   in   rx_byte                                             8
// o_out_ch  out  event_res, data_byte, payload_offset,               3+8+16
//                frame_cmd, frame_len                                +8+16
// i_cfg_*   in   we / idx (0 sync_value, 1 max_payload_len) / data   1/1/16
//
// One byte per cycle sustained while the output is not stalled; each byte passes
// the input register, then parser logic into the result register, before its
// result is offered on the output channel.
// Input ready drops only when both stages hold data and the output is stalled.
// Synchronous active-low reset clears frame state, stage valids and config
// (sync 0xAA, max length 256).
module sync_length_xor_deframer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sldf_in_if.sink                           i_in_ch,
    sldf_out_if.source                        o_out_ch,
    input  logic                              i_cfg_we,
    input  logic [sldf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sldf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sldf_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              advance;
    logic              step;

    assign advance        = !r_out_valid || o_out_ch.ready;
    assign step           = r_in_valid && advance;
    assign i_in_ch.ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_value      <= SYNC_RESET;
            r_cfg.max_payload_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_VALUE: r_cfg.sync_value      <= i_cfg_data[BYTE_W-1:0];
                CFG_MAX_LEN:    r_cfg.max_payload_len <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in_byte <= i_in_ch.rx_byte;
        end
    end

    sldf_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_rx_byte (r_in_byte),
        .i_cfg     (r_cfg),
        .o_res     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.event_res      = r_out.ev_code;
    assign o_out_ch.data_byte      = r_out.data_byte;
    assign o_out_ch.payload_offset = r_out.payload_offset;
    assign o_out_ch.frame_cmd      = r_out.frame_cmd;
    assign o_out_ch.frame_len      = r_out.frame_len;

endmodule

`default_nettype wire

// ===== rtl/sldf_chk.sv =====
`default_nettype none
`include "assert_macros.svh"

module sldf_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [sldf_pkg::EVENT_W-1:0]    i_event_res,
    input logic [sldf_pkg::BYTE_W-1:0]     i_data_byte,
    input logic [sldf_pkg::LEN_W-1:0]      i_payload_offset,
    input logic [sldf_pkg::BYTE_W-1:0]     i_frame_cmd,
    input logic [sldf_pkg::LEN_W-1:0]      i_frame_len
);
    import sldf_pkg::*;

    // stalled result holds still
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_event_res) && $stable(i_data_byte) && $stable(i_payload_offset) && $stable(i_frame_cmd) && $stable(i_frame_len))

    // data fields are zero except on a payload byte
    `ASSERT_SAME(a_idle_zero, i_clk, i_rst_n, i_out_valid && (i_event_res != EV_DATA),
        (i_data_byte == '0) && (i_payload_offset == '0))

    // payload offsets stay inside the frame length
    `ASSERT_SAME(a_off_in_frame, i_clk, i_rst_n, i_out_valid && (i_event_res == EV_DATA),
        i_payload_offset < i_frame_len)

    // an oversize frame never carries a zero length
    `ASSERT_SAME(a_oversize_len, i_clk, i_rst_n,
        i_out_valid && (i_event_res == EV_OVERSIZE), i_frame_len != '0)

    // only defined event codes appear
    `ASSERT_SAME(a_event_code, i_clk, i_rst_n, i_out_valid, i_event_res <= EV_OVERSIZE)

endmodule

bind sync_length_xor_deframer_core sldf_chk u_sldf_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out_ch.valid),
    .i_out_ready      (o_out_ch.ready),
    .i_event_res      (o_out_ch.event_res),
    .i_data_byte      (o_out_ch.data_byte),
    .i_payload_offset (o_out_ch.payload_offset),
    .i_frame_cmd      (o_out_ch.frame_cmd),
    .i_frame_len      (o_out_ch.frame_len)
);

`default_nettype wire
